FILE: src/slwd_pkg.sv
// ----------------------------------------------------------------------------
// slwd_pkg
// Shared types, constants and level mapping functions for the signal loss
// warning detector.
// ----------------------------------------------------------------------------
`default_nettype none

package slwd_pkg;

  localparam int HIST_DEPTH = 6;
  localparam int LVL_W      = 4;
  localparam int WIN_W      = 27;
  localparam int MS_PER_MIN = 60000;

  typedef logic [LVL_W-1:0] level_t;
  typedef logic [1:0]       reason_t;
  typedef logic [WIN_W-1:0] window_t;

  localparam level_t LVL_ZERO  = 4'd0;
  localparam level_t LVL_INIT  = 4'd5;
  localparam level_t LVL_MAX   = 4'd10;
  localparam level_t LVL_LOW   = 4'd3;
  localparam level_t DROP_STEP = 4'd3;

  localparam reason_t REASON_NONE = 2'd0;
  localparam reason_t REASON_DROP = 2'd1;
  localparam reason_t REASON_LOW  = 2'd2;

  localparam logic CFG_WARN_EN  = 1'b0;
  localparam logic CFG_COOLDOWN = 1'b1;

  localparam logic [6:0] CSQ_UNKNOWN = 7'd99;
  localparam logic [6:0] CSQ_SAT     = 7'd31;

  localparam window_t WIN_RESET = window_t'(5 * MS_PER_MIN);

  // (rssi + 100) / 5 clamped, division by reciprocal 52/256
  function automatic level_t wifi_level_f(input logic connected,
                                          input logic signed [7:0] rssi);
    logic signed [9:0] v;
    logic [11:0]       prod;
    level_t            lvl;
    v    = {{2{rssi[7]}}, rssi} + 10'sd100;
    prod = 12'(v[5:0]) * 12'd52;
    if (!connected || v <= 10'sd0) begin
      lvl = LVL_ZERO;
    end else if (v >= 10'sd50) begin
      lvl = LVL_MAX;
    end else begin
      lvl = prod[11:8];
    end
    return lvl;
  endfunction

  // csq * 10 / 31 clamped, division by reciprocal 331/1024
  function automatic level_t cell_level_f(input logic radio,
                                          input logic [6:0] csq);
    logic [13:0] prod;
    level_t      lvl;
    prod = 14'(csq[4:0]) * 14'd331;
    if (!radio || csq == 7'd0 || csq >= CSQ_UNKNOWN) begin
      lvl = LVL_ZERO;
    end else if (csq >= CSQ_SAT) begin
      lvl = LVL_MAX;
    end else begin
      lvl = prod[13:10];
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

FILE: src/slwd_cell.sv
// ----------------------------------------------------------------------------
// slwd_cell
// One history cell: holds a level, takes its neighbor's level on a shift and
// extends the running maximum over the shifted-in values.
// ----------------------------------------------------------------------------
`default_nettype none

module slwd_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    shift_en,
  input  wire  slwd_pkg::level_t din,
  input  wire  slwd_pkg::level_t max_in,
  output logic [3:0]             dout,
  output logic [3:0]             max_out
);
  import slwd_pkg::*;

  level_t lvl_r;
  level_t lvl_nxt;

  always_comb begin
    lvl_nxt = shift_en ? din : lvl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= LVL_INIT;
    end else begin
      lvl_r <= lvl_nxt;
    end
  end

  assign dout    = lvl_r;
  assign max_out = (din > max_in) ? din : max_in;

endmodule

`default_nettype wire

FILE: src/signal_loss_warning_detector.sv
// ----------------------------------------------------------------------------
// signal_loss_warning_detector
// Maps wifi and cellular readings to signal levels, keeps a level history and
// raises rapid drop or sustained low warnings outside a cooldown window.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries one sample per transaction; the
//   result channel out_valid/out_stall returns exactly one result per sample.
//   a sample accepted at an edge shows its result in the output register
//   right after that edge. throughput is one sample per cycle unless a held
//   result stalls the input; the history is a row of cells shifted once per
//   counted sample, so the maximum and low checks finish in the accepting cycle.
//   the output register holds a stalled result stable; in_stall is raised
//   only while a result is held and out_stall is high, and a new sample is
//   accepted in the same cycle the held result is taken.
//   reset (rst_n low, synchronous) fills the history with level 5, clears
//   the last warning time, disables warnings and sets a 5 minute cooldown.
//   cfg_we writes cfg_wdata to register cfg_index (0 warn enable, 1 cooldown
//   minutes); the user must write only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module signal_loss_warning_detector (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire  [10:0]       cfg_wdata,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_wifi_connected,
  input  wire  signed [7:0] in_rssi_dbm,
  input  wire               in_radio_ok,
  input  wire  [6:0]        in_csq_raw,
  input  wire               in_voice_ok,
  input  wire               in_sos_active,
  input  wire  [31:0]       in_now_ms,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [3:0]        out_combined_level,
  output logic [3:0]        out_cell_level,
  output logic [3:0]        out_wifi_level,
  output logic [6:0]        out_csq_report,
  output logic signed [7:0] out_rssi_report,
  output logic              out_warn,
  output logic [1:0]        out_warn_reason
);
  import slwd_pkg::*;

  logic    warn_en_r;
  window_t window_r;
  logic [31:0] last_warn_r;
  logic [31:0] last_warn_nxt;

  logic    out_valid_r;
  logic    out_valid_nxt;
  level_t  comb_lvl_r;
  level_t  cell_lvl_r;
  level_t  wifi_lvl_r;
  logic [6:0]        csq_rep_r;
  logic signed [7:0] rssi_rep_r;
  logic    warn_r;
  reason_t reason_r;

  logic    accept;
  logic    hist_en;
  level_t  wifi_lvl;
  level_t  cell_lvl;
  level_t  level;
  logic [31:0] elapsed;
  logic    cooling;
  logic    rapid;
  logic    lows;
  reason_t reason;
  level_t  peak;

  level_t  nbr   [HIST_DEPTH];
  level_t  mx_ch [HIST_DEPTH];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign hist_en  = accept & warn_en_r & ~in_sos_active;

  assign wifi_lvl = wifi_level_f(in_wifi_connected, in_rssi_dbm);
  assign cell_lvl = cell_level_f(in_radio_ok, in_csq_raw);
  assign level    = (in_voice_ok && cell_lvl != LVL_ZERO) ? cell_lvl : wifi_lvl;

  // history row, newest at cell 0
  assign nbr[0]   = level;
  assign mx_ch[0] = LVL_ZERO;

  for (genvar i = 0; i < HIST_DEPTH - 1; i++) begin : g_cell
    slwd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (hist_en),
      .din      (nbr[i]),
      .max_in   (mx_ch[i]),
      .dout     (nbr[i+1]),
      .max_out  (mx_ch[i+1])
    );
  end

  assign peak = (nbr[HIST_DEPTH-1] > mx_ch[HIST_DEPTH-1]) ? nbr[HIST_DEPTH-1] :
                mx_ch[HIST_DEPTH-1];

  assign elapsed = in_now_ms - last_warn_r;
  assign cooling = (last_warn_r != 32'd0) && (elapsed < 32'(window_r));
  assign rapid   = {1'b0, peak} >= ({1'b0, level} + {1'b0, DROP_STEP});
  assign lows    = (nbr[0] <= LVL_LOW) && (nbr[1] <= LVL_LOW) && (nbr[2] <= LVL_LOW);

  always_comb begin
    if (!hist_en || cooling) begin
      reason = REASON_NONE;
    end else if (rapid) begin
      reason = REASON_DROP;
    end else if (lows) begin
      reason = REASON_LOW;
    end else begin
      reason = REASON_NONE;
    end
  end

  always_comb begin
    last_warn_nxt = (reason != REASON_NONE) ? in_now_ms : last_warn_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_en_r   <= 1'b0;
      window_r    <= WIN_RESET;
      last_warn_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      last_warn_r <= last_warn_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WARN_EN: begin
            warn_en_r <= cfg_wdata[0];
          end
          CFG_COOLDOWN: begin
            window_r <= window_t'(cfg_wdata) * window_t'(MS_PER_MIN);
          end
          default: begin
            warn_en_r <= warn_en_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      comb_lvl_r <= level;
      cell_lvl_r <= cell_lvl;
      wifi_lvl_r <= wifi_lvl;
      csq_rep_r  <= in_radio_ok ? in_csq_raw : CSQ_UNKNOWN;
      rssi_rep_r <= in_wifi_connected ? in_rssi_dbm : 8'sd0;
      warn_r     <= (reason != REASON_NONE);
      reason_r   <= reason;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_combined_level = comb_lvl_r;
  assign out_cell_level     = cell_lvl_r;
  assign out_wifi_level     = wifi_lvl_r;
  assign out_csq_report     = csq_rep_r;
  assign out_rssi_report    = rssi_rep_r;
  assign out_warn           = warn_r;
  assign out_warn_reason    = reason_r;

`ifndef SYNTH
  a_warn_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_warn == (out_warn_reason != REASON_NONE)))
    else $error("warn flag and reason disagree");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a held result");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_combined_level <= LVL_MAX && out_cell_level <= LVL_MAX &&
                   out_wifi_level <= LVL_MAX))
    else $error("level out of range");

  a_warn_time: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && reason != REASON_NONE) |=> (last_warn_r == $past(in_now_ms)))
    else $error("last warning time not captured");
`endif

endmodule

`default_nettype wire
